### rtl/bds_pkg.sv
// bds_pkg: types, register indexes and reset values for balance_drive_shaper.
// Used by the register bank, the stages and the top level; no dependencies.

package bds_pkg;

	// Configuration register indexes, in port order
	typedef enum logic [2:0] {
		REG_MIN_BOOST_ANGLE   = 3'd0,
		REG_MIN_COMMAND       = 3'd1,
		REG_LEAN_BOOST_ANGLE  = 3'd2,
		REG_LEAN_BOOST_GAIN   = 3'd3,
		REG_DAMPING_MAX_ANGLE = 3'd4,
		REG_DAMPING_GAIN      = 3'd5,
		REG_MAX_COMMAND       = 3'd6
	} reg_idx_t;

	localparam logic [14:0] RST_MIN_BOOST_ANGLE   = 15'd256;
	localparam logic [14:0] RST_MIN_COMMAND       = 15'd0;
	localparam logic [14:0] RST_LEAN_BOOST_ANGLE  = 15'd2560;
	localparam logic [15:0] RST_LEAN_BOOST_GAIN   = 16'd0;
	localparam logic [14:0] RST_DAMPING_MAX_ANGLE = 15'd1280;
	localparam logic [15:0] RST_DAMPING_GAIN      = 16'd0;
	localparam logic [14:0] RST_MAX_COMMAND       = 15'd255;

	typedef struct packed {
		logic [14:0]        min_boost_angle;
		logic [14:0]        min_command;
		logic [14:0]        lean_boost_angle;
		logic [15:0]        lean_boost_gain;
		logic [14:0]        damping_max_angle;
		logic signed [15:0] damping_gain;
		logic [14:0]        max_command;
	} cfg_t;

	// After floor stage
	typedef struct packed {
		logic signed [15:0] cmd;
		logic               err_neg;
		logic               boost_en;
		logic               damp_en;
		logic [15:0]        excess;
		logic signed [15:0] speed;
	} front_t;

	// After the two products
	typedef struct packed {
		logic signed [15:0] cmd;
		logic               err_neg;
		logic               boost_en;
		logic               damp_en;
		logic [31:0]        extra;
		logic signed [31:0] prod;
	} mul_t;

	// After lean boost
	typedef struct packed {
		logic signed [15:0] cmd;
		logic               damp_en;
		logic signed [31:0] prod;
	} boost_t;

endpackage

### rtl/bds_stream_if.sv
// bds_stream_if: valid/ready channel interfaces for balance_drive_shaper.
// Input channel carries one sample, output channel one shaped command.

interface bds_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] raw_command;
	logic signed [15:0] angle_error;
	logic signed [15:0] wheel_speed;

	modport source (output valid, output raw_command, output angle_error,
		output wheel_speed, input ready);
	modport sink (input valid, input raw_command, input angle_error,
		input wheel_speed, output ready);
endinterface

interface bds_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] motor_command;

	modport source (output valid, output motor_command, input ready);
	modport sink (input valid, input motor_command, output ready);
endinterface

### rtl/bds_cfg_regs.sv
// bds_cfg_regs: configuration register bank of balance_drive_shaper.
// Depends on bds_pkg.

module bds_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [15:0]   wr_data,
	output bds_pkg::cfg_t cfg
);
	import bds_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_boost_angle   <= RST_MIN_BOOST_ANGLE;
			cfg_q.min_command       <= RST_MIN_COMMAND;
			cfg_q.lean_boost_angle  <= RST_LEAN_BOOST_ANGLE;
			cfg_q.lean_boost_gain   <= RST_LEAN_BOOST_GAIN;
			cfg_q.damping_max_angle <= RST_DAMPING_MAX_ANGLE;
			cfg_q.damping_gain      <= $signed(RST_DAMPING_GAIN);
			cfg_q.max_command       <= RST_MAX_COMMAND;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MIN_BOOST_ANGLE:   cfg_q.min_boost_angle   <= wr_data[14:0];
				REG_MIN_COMMAND:       cfg_q.min_command       <= wr_data[14:0];
				REG_LEAN_BOOST_ANGLE:  cfg_q.lean_boost_angle  <= wr_data[14:0];
				REG_LEAN_BOOST_GAIN:   cfg_q.lean_boost_gain   <= wr_data;
				REG_DAMPING_MAX_ANGLE: cfg_q.damping_max_angle <= wr_data[14:0];
				REG_DAMPING_GAIN:      cfg_q.damping_gain      <= $signed(wr_data);
				REG_MAX_COMMAND:       cfg_q.max_command       <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

### rtl/bds_front.sv
// bds_front: input register stage; absolute error, window decisions and
// the minimum command floor. Depends on bds_pkg.

module bds_front (
	input  logic               clk,
	input  logic               arst_n,
	input  bds_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] raw_command,
	input  logic signed [15:0] angle_error,
	input  logic signed [15:0] wheel_speed,
	output logic               out_valid,
	input  logic               out_ready,
	output bds_pkg::front_t    out_data
);
	import bds_pkg::*;

	logic               valid_s1;
	front_t             data_s1;
	front_t             nxt;
	logic               err_neg;
	logic signed [16:0] err17;
	logic [16:0]        aerr;
	logic signed [15:0] minc;
	logic               floor_en;

	always_comb begin
		err_neg  = angle_error[15];
		err17    = 17'(angle_error);
		// full-scale negative error gives 32768, no wrap in 17 bits
		aerr     = err_neg ? 17'(-err17) : 17'(err17);
		minc     = $signed({1'b0, cfg.min_command});
		floor_en = (aerr >= {2'b00, cfg.min_boost_angle}) && (cfg.min_command != '0);

		nxt.cmd = raw_command;
		if (floor_en) begin
			if (raw_command > 16'sd0 && raw_command < minc)
				nxt.cmd = minc;
			else if (raw_command < 16'sd0 && raw_command > -minc)
				nxt.cmd = -minc;
		end
		nxt.err_neg  = err_neg;
		nxt.boost_en = aerr > {2'b00, cfg.lean_boost_angle};
		nxt.excess   = 16'(aerr - {2'b00, cfg.lean_boost_angle});
		nxt.damp_en  = aerr <= {2'b00, cfg.damping_max_angle};
		nxt.speed    = wheel_speed;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;
endmodule

### rtl/bds_mul.sv
// bds_mul: product stage; boost excess times gain and speed times damping gain.
// Depends on bds_pkg.

module bds_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  bds_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  bds_pkg::front_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output bds_pkg::mul_t   out_data
);
	import bds_pkg::*;

	logic valid_s2;
	mul_t data_s2;
	mul_t nxt;

	always_comb begin
		nxt.cmd      = in_data.cmd;
		nxt.err_neg  = in_data.err_neg;
		nxt.boost_en = in_data.boost_en;
		nxt.damp_en  = in_data.damp_en;
		nxt.extra    = 32'(in_data.excess) * 32'(cfg.lean_boost_gain);
		nxt.prod     = 32'(in_data.speed) * 32'(cfg.damping_gain);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;
endmodule

### rtl/bds_boost.sv
// bds_boost: lean boost stage; adds or subtracts the Q16.16 boost, saturates
// and truncates toward zero. Depends on bds_pkg.

module bds_boost (
	input  logic             clk,
	input  logic             arst_n,
	input  bds_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  bds_pkg::mul_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bds_pkg::boost_t  out_data
);
	import bds_pkg::*;

	logic               valid_s3;
	boost_t             data_s3;
	boost_t             nxt;
	logic signed [33:0] addend;
	logic signed [33:0] sum;
	logic signed [33:0] lim;
	logic signed [15:0] maxc;

	always_comb begin
		addend = $signed({2'b00, in_data.extra});
		sum    = in_data.err_neg ? (34'(in_data.cmd) <<< 16) + addend
			: (34'(in_data.cmd) <<< 16) - addend;
		lim    = $signed({3'b000, cfg.max_command, 16'h0000});
		maxc   = $signed({1'b0, cfg.max_command});

		nxt.cmd = in_data.cmd;
		if (in_data.boost_en) begin
			if (sum > lim)
				nxt.cmd = maxc;
			else if (sum < -lim)
				nxt.cmd = -maxc;
			else
				// arithmetic shift floors; round negatives with a fraction up
				nxt.cmd = sum[31:16] + 16'((sum[33] && sum[15:0] != '0) ? 1 : 0);
		end
		nxt.damp_en = in_data.damp_en;
		nxt.prod    = in_data.prod;
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;
endmodule

### rtl/bds_damp.sv
// bds_damp: wheel damping stage and result register; subtracts the Q20.12
// damping product, saturates and truncates toward zero. Depends on bds_pkg.

module bds_damp (
	input  logic               clk,
	input  logic               arst_n,
	input  bds_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  bds_pkg::boost_t    in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] motor_command
);
	import bds_pkg::*;

	logic               valid_q;
	logic signed [15:0] cmd_q;
	logic signed [15:0] nxt;
	logic signed [33:0] sum;
	logic signed [33:0] lim;
	logic signed [15:0] maxc;

	always_comb begin
		sum  = (34'(in_data.cmd) <<< 12) - 34'(in_data.prod);
		lim  = $signed({7'd0, cfg.max_command, 12'h000});
		maxc = $signed({1'b0, cfg.max_command});

		nxt = in_data.cmd;
		if (in_data.damp_en) begin
			if (sum > lim)
				nxt = maxc;
			else if (sum < -lim)
				nxt = -maxc;
			else
				nxt = sum[27:12] + 16'((sum[33] && sum[11:0] != '0) ? 1 : 0);
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q <= nxt;
		end
	end

	assign out_valid     = valid_q;
	assign motor_command = cmd_q;
endmodule

### rtl/balance_drive_shaper.sv
// balance_drive_shaper: top level; floor, lean boost and wheel damping of a
// balance motor command. Depends on bds_pkg, bds_stream_if and the bds_ stages.
//
//  port     | kind          | request carries
//  ---------+---------------+------------------------------------------
//  in_ch    | valid/ready   | raw_command, angle_error, wheel_speed
//  out_ch   | valid/ready   | motor_command
//  wr_*     | write strobe  | register index 0..6, data in wr_data
//
// One request per cycle sustained while out_ch is not stalled; a request
// passes the four register stages (floor, products, boost, damping) before
// out_ch.valid. Each stage holds its request while the one after it is full
// and stalled, so bubbles are absorbed and input keeps flowing.
// arst_n empties every stage and loads register reset values.

module balance_drive_shaper (
	input  logic        clk,
	input  logic        arst_n,
	bds_in_if.sink      in_ch,
	bds_out_if.source   out_ch,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);
	import bds_pkg::*;

	cfg_t   cfg;
	front_t front_data;
	mul_t   mul_data;
	boost_t boost_data;
	logic   front_valid, front_ready;
	logic   mul_valid, mul_ready;
	logic   boost_valid, boost_ready;

	bds_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bds_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.raw_command (in_ch.raw_command),
		.angle_error (in_ch.angle_error),
		.wheel_speed (in_ch.wheel_speed),
		.out_valid   (front_valid),
		.out_ready   (front_ready),
		.out_data    (front_data)
	);

	bds_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (mul_valid),
		.out_ready (mul_ready),
		.out_data  (mul_data)
	);

	bds_boost u_boost (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (mul_valid),
		.in_ready  (mul_ready),
		.in_data   (mul_data),
		.out_valid (boost_valid),
		.out_ready (boost_ready),
		.out_data  (boost_data)
	);

	bds_damp u_damp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (boost_valid),
		.in_ready      (boost_ready),
		.in_data       (boost_data),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.motor_command (out_ch.motor_command)
	);
endmodule

### rtl/bds_checker.sv
// bds_checker: port-level checks on balance_drive_shaper, attached by bind.
// Depends on bds_stream_if through the bound connections.

module bds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] motor_command
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(motor_command))
		else $error("result dropped or changed while stalled");

	// with no result waiting, no stage can be blocked
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a ready output never blocks the input
	a_ready_when_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked although output is draining");

	// reset empties the result register
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid straight after reset");

endmodule

bind balance_drive_shaper bds_checker u_bds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.motor_command (out_ch.motor_command)
);
